@@ rtl/grc_pkg.sv @@
`timescale 1ns / 1ps

package grc_pkg;

    localparam int MAP_SIDE_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam int POS_W   = 22;
    localparam int VEC_W   = 18;
    localparam int SCR_W   = 13;
    localparam int COL_W   = 12;
    localparam int CELL_W  = 6;
    localparam int DIST_W  = 24;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_X   = 3'd0,
        CFG_POS_Y   = 3'd1,
        CFG_DIR_X   = 3'd2,
        CFG_DIR_Y   = 3'd3,
        CFG_PLANE_X = 3'd4,
        CFG_PLANE_Y = 3'd5,
        CFG_SCR_W   = 3'd6,
        CFG_NONE    = 3'd7
    } grc_cfg_idx_t;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam logic [1:0] TEX_NORTH = 2'd0;
    localparam logic [1:0] TEX_SOUTH = 2'd1;
    localparam logic [1:0] TEX_EAST  = 2'd2;
    localparam logic [1:0] TEX_WEST  = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic              cell_wall;
        logic [COL_W-1:0]  column;
    } grc_in_t;

    typedef struct packed {
        logic [DIST_W-1:0] wall_distance;
        logic              hit_side;
        logic [1:0]        texture_index;
        logic [CELL_W-1:0] hit_x;
        logic [CELL_W-1:0] hit_y;
        logic              hit_found;
    } grc_out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_OFF,
        ST_MUL_X,
        ST_MUL_Y,
        ST_RAY_Y,
        ST_DIV_X,
        ST_DIV_Y,
        ST_MUL_SX,
        ST_MUL_SY,
        ST_SIDE_Y,
        ST_STEP,
        ST_CHECK,
        ST_DONE
    } grc_state_t;

endpackage

@@ rtl/grid_ray_caster.sv @@
`timescale 1ns / 1ps

// Map write beats are taken in the idle state without leaving it. A cast beat runs three divisions
// in the shared restoring divider (NUMW = 33 at FRAC_BITS 16), multiply and setup steps, a walk
// over grid cells (one map read each, up to 2*MAP_SIDE+4 cells) and a load of the output
// register. One beat is in work at a time; the next beat is taken as soon as the result
// register is free. After reset the map is cleared one cell per cycle before the first beat;
// configuration writes are taken meanwhile.
module grid_ray_caster
    import grc_pkg::*;
#(
    parameter int MAP_SIDE  = MAP_SIDE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  grc_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output grc_out_t             out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POS_W-1:0]     cfg_wdata
);

    localparam int F     = FRAC_BITS;
    localparam int MAPW  = $clog2(MAP_SIDE);
    localparam int AddrW = 2 * MAPW;
    localparam int Depth = 1 << AddrW;
    localparam int NUMW  = (COL_W + 1 + F > 2 * F + 1) ? COL_W + 1 + F : 2 * F + 1;
    localparam int DENW  = (SCR_W > F + 2) ? SCR_W : F + 2;
    localparam int QW    = NUMW + 1;
    localparam int DW    = F + 8;
    localparam int VW    = F + 3;
    localparam int FW    = F + 1;
    localparam int AW    = (VEC_W > F + 2) ? VEC_W : F + 2;
    localparam int BW    = (QW > DW + 1) ? QW : DW + 1;
    localparam int PW    = AW + BW;
    localparam int IPW   = (POS_W - F > MAPW) ? POS_W - F : MAPW;
    localparam int CW    = IPW + 2;
    localparam int Steps = 2 * MAP_SIDE + 4;
    localparam int NW    = $clog2(Steps + 1);
    localparam int CNTW  = $clog2(NUMW + 1);

    localparam logic [DW-1:0]   DMAX   = {DW{1'b1}};
    localparam logic [FW-1:0]   ONE_F  = FW'(1) << F;
    localparam logic [FW-1:0]   FMASK  = ONE_F - FW'(1);
    localparam logic signed [PW-1:0] VMAX = (PW'(2) << F) - PW'(1);
    localparam logic signed [PW-1:0] VMIN = -(PW'(2) << F);
    localparam logic signed [PW-1:0] RND  = (PW'(1) << F) - PW'(1);

    grc_state_t state_reg, state_next;

    logic [POS_W-1:0]        pos_x_reg, pos_y_reg;
    logic signed [VEC_W-1:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [SCR_W-1:0]        scr_w_reg;

    logic [AddrW-1:0]        clr_reg;
    logic [COL_W-1:0]        col_reg;
    logic [CNTW-1:0]         cnt_reg;
    logic [NUMW-1:0]         div_num_reg, div_quo_reg;
    logic [DENW-1:0]         div_rem_reg;
    logic signed [QW-1:0]    off_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [VW-1:0]    rx_reg, ry_reg;
    logic [DW-1:0]           ddx_reg, ddy_reg, sdx_reg, sdy_reg, perp_reg;
    logic signed [CW-1:0]    mx_reg, my_reg;
    logic                    side_reg;
    logic                    hit_reg;
    logic [NW-1:0]           n_reg;
    logic                    rd_reg;
    logic                    out_valid_reg;
    grc_out_t                out_data_reg;

    logic wall_mem [Depth];

    // Divider datapath.
    logic [DENW-1:0]  div_den;
    logic [NUMW-1:0]  div_load;
    logic [DENW:0]    rem_sh;
    logic             div_ge;
    logic [DENW-1:0]  rem_nx;
    logic [NUMW-1:0]  quo_nx;
    logic [DW-1:0]    quo_sat;
    logic signed [QW-1:0] off_nx;
    logic [VW-1:0]    abs_rx, abs_ry;
    logic             div_last;

    always_comb
    begin
        abs_rx = rx_reg[VW-1] ? VW'(-rx_reg) : VW'(rx_reg);
        abs_ry = ry_reg[VW-1] ? VW'(-ry_reg) : VW'(ry_reg);
        case (state_reg)
            ST_DIV_OFF:
            begin
                div_den  = (scr_w_reg == '0) ? DENW'(1) : DENW'(scr_w_reg);
                div_load = NUMW'({col_reg, 1'b0}) << F;
            end
            ST_DIV_X:
            begin
                div_den  = DENW'(abs_rx);
                div_load = NUMW'(1) << (2 * F);
            end
            default:
            begin
                div_den  = DENW'(abs_ry);
                div_load = NUMW'(1) << (2 * F);
            end
        endcase
        rem_sh   = {div_rem_reg, div_num_reg[NUMW-1]};
        div_ge   = rem_sh >= {1'b0, div_den};
        rem_nx   = div_ge ? DENW'(rem_sh - {1'b0, div_den}) : DENW'(rem_sh);
        quo_nx   = {div_quo_reg[NUMW-2:0], div_ge};
        quo_sat  = (quo_nx > NUMW'(DMAX)) ? DMAX : DW'(quo_nx);
        off_nx   = $signed({1'b0, quo_nx}) - QW'(ONE_F);
        div_last = cnt_reg == CNTW'(NUMW);
    end

    // Shared multiplier.
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic [FW-1:0]        fx, fy, frac_x, frac_y;

    always_comb
    begin
        fx     = FW'(pos_x_reg) & FMASK;
        fy     = FW'(pos_y_reg) & FMASK;
        frac_x = rx_reg[VW-1] ? fx : ONE_F - fx;
        frac_y = ry_reg[VW-1] ? fy : ONE_F - fy;
        case (state_reg)
            ST_MUL_X:
            begin
                mul_a = AW'(plane_x_reg);
                mul_b = BW'(off_reg);
            end
            ST_MUL_Y:
            begin
                mul_a = AW'(plane_y_reg);
                mul_b = BW'(off_reg);
            end
            ST_MUL_SX:
            begin
                mul_a = $signed(AW'(frac_x));
                mul_b = $signed(BW'(ddx_reg));
            end
            default:
            begin
                mul_a = $signed(AW'(frac_y));
                mul_b = $signed(BW'(ddy_reg));
            end
        endcase
    end

    // Ray component from the registered product: truncate toward zero, add, saturate.
    function automatic logic signed [VW-1:0] ray_of(input logic signed [PW-1:0] p,
                                                    input logic signed [VEC_W-1:0] d);
        logic signed [PW-1:0] t;
        logic signed [PW-1:0] r;
        begin
            t = (p[PW-1] ? p + RND : p) >>> F;
            r = PW'(d) + t;
            if (r > VMAX)
                r = VMAX;
            else if (r < VMIN)
                r = VMIN;
            ray_of = VW'(r);
        end
    endfunction

    function automatic logic [DW-1:0] side_of(input logic signed [PW-1:0] p,
                                              input logic [DW-1:0] dd);
        logic [PW-1:0] v;
        begin
            v = PW'($unsigned(p)) >> F;
            if (dd == DMAX || v > PW'(DMAX))
                side_of = DMAX;
            else
                side_of = DW'(v);
        end
    endfunction

    // One walk step.
    logic                 step_x;
    logic [DW:0]          sum_x, sum_y;
    logic signed [CW-1:0] mx_nx, my_nx;
    logic                 out_map;
    logic [AddrW-1:0]     rd_addr;

    always_comb
    begin
        step_x  = sdx_reg < sdy_reg;
        sum_x   = {1'b0, sdx_reg} + {1'b0, ddx_reg};
        sum_y   = {1'b0, sdy_reg} + {1'b0, ddy_reg};
        mx_nx   = mx_reg;
        my_nx   = my_reg;
        if (step_x)
            mx_nx = rx_reg[VW-1] ? mx_reg - CW'(1) : mx_reg + CW'(1);
        else
            my_nx = ry_reg[VW-1] ? my_reg - CW'(1) : my_reg + CW'(1);
        out_map = mx_nx[CW-1] || my_nx[CW-1]
                  || (mx_nx >= CW'(MAP_SIDE)) || (my_nx >= CW'(MAP_SIDE));
        rd_addr = {mx_nx[MAPW-1:0], my_nx[MAPW-1:0]};
    end

    // Map write port.
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic             wr_bit;
    logic             in_fire;

    always_comb
    begin
        in_fire = in_valid && in_ready;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_bit  = 1'b0;
        end
        else
        begin
            wr_en   = in_fire && (in_data.cmd == CMD_WRITE)
                      && ((MAPW + 1)'(in_data.cell_x) < (MAPW + 1)'(MAP_SIDE))
                      && ((MAPW + 1)'(in_data.cell_y) < (MAPW + 1)'(MAP_SIDE));
            wr_addr = {MAPW'(in_data.cell_x), MAPW'(in_data.cell_y)};
            wr_bit  = in_data.cell_wall;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            wall_mem[wr_addr] <= wr_bit;
        rd_reg <= wall_mem[rd_addr];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_reg == AddrW'(Depth - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_fire && in_data.cmd == CMD_CAST)
                    state_next = ST_DIV_OFF;
            ST_DIV_OFF:
                if (div_last)
                    state_next = ST_MUL_X;
            ST_MUL_X:  state_next = ST_MUL_Y;
            ST_MUL_Y:  state_next = ST_RAY_Y;
            ST_RAY_Y:  state_next = ST_DIV_X;
            ST_DIV_X:
                if (div_last)
                    state_next = ST_DIV_Y;
            ST_DIV_Y:
                if (div_last)
                    state_next = ST_MUL_SX;
            ST_MUL_SX: state_next = ST_MUL_SY;
            ST_MUL_SY: state_next = ST_SIDE_Y;
            ST_SIDE_Y: state_next = ST_STEP;
            ST_STEP:
                if (n_reg == NW'(Steps) || out_map)
                    state_next = ST_DONE;
                else
                    state_next = ST_CHECK;
            ST_CHECK:
                state_next = rd_reg ? ST_DONE : ST_STEP;
            ST_DONE:
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_ready  = state_reg == ST_IDLE;
        out_valid = out_valid_reg;
        out_data  = out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= POS_W'(98304);
            pos_y_reg     <= POS_W'(98304);
            dir_x_reg     <= VEC_W'(65536);
            dir_y_reg     <= '0;
            plane_x_reg   <= '0;
            plane_y_reg   <= VEC_W'(43254);
            scr_w_reg     <= SCR_W'(640);
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + AddrW'(1);
            if (cfg_we)
            begin
                unique case (grc_cfg_idx_t'(cfg_index))
                    CFG_POS_X:   pos_x_reg   <= cfg_wdata;
                    CFG_POS_Y:   pos_y_reg   <= cfg_wdata;
                    CFG_DIR_X:   dir_x_reg   <= cfg_wdata[VEC_W-1:0];
                    CFG_DIR_Y:   dir_y_reg   <= cfg_wdata[VEC_W-1:0];
                    CFG_PLANE_X: plane_x_reg <= cfg_wdata[VEC_W-1:0];
                    CFG_PLANE_Y: plane_y_reg <= cfg_wdata[VEC_W-1:0];
                    CFG_SCR_W:   scr_w_reg   <= cfg_wdata[SCR_W-1:0];
                    default:     ;
                endcase
            end
            if (state_reg == ST_DIV_OFF || state_reg == ST_DIV_X || state_reg == ST_DIV_Y)
                cnt_reg <= div_last ? '0 : cnt_reg + CNTW'(1);
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                col_reg <= in_data.column;
            ST_DIV_OFF, ST_DIV_X, ST_DIV_Y:
            begin
                if (cnt_reg == '0)
                begin
                    div_rem_reg <= '0;
                    div_quo_reg <= '0;
                    div_num_reg <= div_load;
                end
                else
                begin
                    div_rem_reg <= rem_nx;
                    div_quo_reg <= quo_nx;
                    div_num_reg <= {div_num_reg[NUMW-2:0], 1'b0};
                end
                if (div_last)
                begin
                    if (state_reg == ST_DIV_OFF)
                        off_reg <= off_nx;
                    else if (state_reg == ST_DIV_X)
                        ddx_reg <= quo_sat;
                    else
                        ddy_reg <= quo_sat;
                end
            end
            ST_MUL_X:
                prod_reg <= PW'(mul_a) * PW'(mul_b);
            ST_MUL_Y:
            begin
                prod_reg <= PW'(mul_a) * PW'(mul_b);
                rx_reg   <= ray_of(prod_reg, dir_x_reg);
            end
            ST_RAY_Y:
                ry_reg <= ray_of(prod_reg, dir_y_reg);
            ST_MUL_SX:
            begin
                prod_reg <= PW'(mul_a) * PW'(mul_b);
                mx_reg   <= CW'(pos_x_reg >> F);
                my_reg   <= CW'(pos_y_reg >> F);
                n_reg    <= '0;
                side_reg <= 1'b0;
                perp_reg <= DMAX;
                hit_reg  <= 1'b0;
            end
            ST_MUL_SY:
            begin
                prod_reg <= PW'(mul_a) * PW'(mul_b);
                sdx_reg  <= side_of(prod_reg, ddx_reg);
            end
            ST_SIDE_Y:
                sdy_reg <= side_of(prod_reg, ddy_reg);
            ST_STEP:
                if (n_reg != NW'(Steps))
                begin
                    n_reg  <= n_reg + NW'(1);
                    mx_reg <= mx_nx;
                    my_reg <= my_nx;
                    if (step_x)
                    begin
                        perp_reg <= sdx_reg;
                        sdx_reg  <= sum_x[DW] ? DMAX : sum_x[DW-1:0];
                        side_reg <= 1'b0;
                    end
                    else
                    begin
                        perp_reg <= sdy_reg;
                        sdy_reg  <= sum_y[DW] ? DMAX : sum_y[DW-1:0];
                        side_reg <= 1'b1;
                    end
                end
            ST_CHECK:
                hit_reg <= rd_reg;
            ST_DONE:
                if (!out_valid_reg || out_ready)
                begin
                    if (hit_reg)
                    begin
                        out_data_reg.wall_distance <= DIST_W'(perp_reg);
                        out_data_reg.hit_side      <= side_reg;
                        if (side_reg)
                            out_data_reg.texture_index <= ry_reg[VW-1] ? TEX_SOUTH : TEX_NORTH;
                        else
                            out_data_reg.texture_index <= rx_reg[VW-1] ? TEX_WEST : TEX_EAST;
                        out_data_reg.hit_x     <= CELL_W'(mx_reg);
                        out_data_reg.hit_y     <= CELL_W'(my_reg);
                        out_data_reg.hit_found <= 1'b1;
                    end
                    else
                    begin
                        out_data_reg.wall_distance <= DIST_W'(DMAX);
                        out_data_reg.hit_side      <= 1'b0;
                        out_data_reg.texture_index <= TEX_NORTH;
                        out_data_reg.hit_x         <= '0;
                        out_data_reg.hit_y         <= '0;
                        out_data_reg.hit_found     <= 1'b0;
                    end
                end
            default:
                ;
        endcase
    end

endmodule
